FILE: hw/rtl/ctbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbl_pkg: shared types and constants of the cursor text buffer
// Node store geometry, command and status codes, channel payload structs.
// ----------------------------------------------------------------------------
package ctbl_pkg;

	localparam int NODES  = 1024;
	localparam int IDX_W  = $clog2(NODES);
	localparam int FREE_W = IDX_W + 1;

	localparam logic [2:0] MODE_INSERT  = 3'd0;
	localparam logic [2:0] MODE_LEFT    = 3'd1;
	localparam logic [2:0] MODE_RIGHT   = 3'd2;
	localparam logic [2:0] MODE_BACKSP  = 3'd3;
	localparam logic [2:0] MODE_RESTART = 3'd4;
	localparam logic [2:0] MODE_NEXT    = 3'd5;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_END     = 2'd3;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] char_in;
	} ctbl_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] char_out;
	} ctbl_rsp_t;

	typedef struct packed {
		logic             we_chr;
		logic             we_prev;
		logic             we_next;
		logic [IDX_W-1:0] addr;
		logic [7:0]       chr;
		logic [IDX_W-1:0] prev;
		logic [IDX_W-1:0] nxt;
	} ctbl_mem_req_t;

	typedef struct packed {
		logic [7:0]       chr;
		logic [IDX_W-1:0] prev;
		logic [IDX_W-1:0] nxt;
	} ctbl_node_t;

endpackage

FILE: hw/rtl/cursor_text_buffer_linked_core.sv
`timescale 1ns / 1ps
// Insert takes the longest path from request accept to response valid.
// A new request is taken only once the sequencer has handed the last result on.
// Reset: cursor, readout pointer and head link clear at once, the free slot counter
// restarts at 1; the node memory is not cleared and only written entries are used.
// ----------------------------------------------------------------------------
// cursor_text_buffer_linked_core: linked-list text buffer with a cursor
// Edits and reads a text held as a doubly linked list in a node memory,
// one request at a time, with a registered response stage.
// ----------------------------------------------------------------------------
module cursor_text_buffer_linked_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ctbl_pkg::ctbl_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ctbl_pkg::ctbl_rsp_t rsp
);
	import ctbl_pkg::*;

	ctbl_mem_req_t mreq;
	ctbl_node_t    rdata;
	ctbl_rsp_t     res;
	ctbl_rsp_t     rsp_q;
	logic          res_valid;
	logic          res_ready;
	logic          rsp_valid_q;

	// sequencer: one request at a time through the node memory port
	ctbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mreq      (mreq),
		.rdata     (rdata)
	);

	// node store: character plus both links per slot
	ctbl_node_mem u_mem (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	// response register: take a new result when empty or being drained,
	// so the sequencer can accept the next request while this one waits
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// hold payload until taken
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: hw/rtl/ctbl_node_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbl_node_mem: node store of the linked text buffer
// Single-port synchronous memory holding character, prev and next link of
// every node, with a write enable per field and a registered read.
// ----------------------------------------------------------------------------
module ctbl_node_mem (
	input  logic                   clk,
	input  ctbl_pkg::ctbl_mem_req_t mreq,
	output ctbl_pkg::ctbl_node_t    rdata
);
	import ctbl_pkg::*;

	logic [7:0]       chr_mem  [NODES];
	logic [IDX_W-1:0] prev_mem [NODES];
	logic [IDX_W-1:0] next_mem [NODES];

	// write the enabled fields, read all fields at the same address
	always_ff @(posedge clk) begin
		if (mreq.we_chr) begin
			chr_mem[mreq.addr] <= mreq.chr;
		end
		if (mreq.we_prev) begin
			prev_mem[mreq.addr] <= mreq.prev;
		end
		if (mreq.we_next) begin
			next_mem[mreq.addr] <= mreq.nxt;
		end
		rdata.chr  <= chr_mem[mreq.addr];
		rdata.prev <= prev_mem[mreq.addr];
		rdata.nxt  <= next_mem[mreq.addr];
	end

endmodule

FILE: hw/rtl/ctbl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctbl_ctrl: command sequencer of the linked text buffer
// Reads a node, then writes back the changed links one port access a cycle;
// the head sentinel's next link lives in a register.
// ----------------------------------------------------------------------------
module ctbl_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  ctbl_pkg::ctbl_req_t     req,
	output logic                    res_valid,
	input  logic                    res_ready,
	output ctbl_pkg::ctbl_rsp_t     res,
	output ctbl_pkg::ctbl_mem_req_t mreq,
	input  ctbl_pkg::ctbl_node_t    rdata
);
	import ctbl_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EXEC = 7'b0000010,
		S_USE  = 7'b0000100,
		S_WA   = 7'b0001000,
		S_WB   = 7'b0010000,
		S_CHAR = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	localparam logic [IDX_W-1:0] HEAD = '0;

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  cursor_q, cursor_d;
	logic [IDX_W-1:0]  read_q, read_d;
	logic [FREE_W-1:0] free_q, free_d;
	logic [IDX_W-1:0]  head_next_q, head_next_d;
	logic [2:0]        mode_q, mode_d;
	logic [7:0]        ch_q, ch_d;
	logic [IDX_W-1:0]  nx_q, nx_d;
	logic [IDX_W-1:0]  pv_q, pv_d;
	logic [1:0]        status_q, status_d;
	logic [7:0]        char_q, char_d;
	logic [IDX_W-1:0]  cur_next;
	logic [IDX_W-1:0]  slot;

	assign slot      = free_q[IDX_W-1:0];
	assign cur_next  = (cursor_q == HEAD) ? head_next_q : rdata.nxt;
	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res.status   = status_q;
	assign res.char_out = char_q;

	always_comb begin
		state_d     = state_q;
		cursor_d    = cursor_q;
		read_d      = read_q;
		free_d      = free_q;
		head_next_d = head_next_q;
		mode_d      = mode_q;
		ch_d        = ch_q;
		nx_d        = nx_q;
		pv_d        = pv_q;
		status_d    = status_q;
		char_d      = char_q;
		mreq        = '0;
		mreq.addr   = cursor_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					mode_d  = req.mode;
					ch_d    = req.char_in;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				status_d = ST_DONE;
				char_d   = '0;
				state_d  = S_DONE;
				case (mode_q)
					MODE_INSERT: begin
						if (free_q == FREE_W'(NODES)) begin
							status_d = ST_FULL;
						end else begin
							state_d = S_USE;
						end
					end
					MODE_LEFT, MODE_BACKSP: begin
						if (cursor_q == HEAD) begin
							status_d = ST_IGNORED;
						end else begin
							state_d = S_USE;
						end
					end
					MODE_RIGHT: begin
						state_d = S_USE;
					end
					MODE_RESTART: begin
						read_d    = head_next_q;
						mreq.addr = head_next_q;
						if (head_next_q == HEAD) begin
							status_d = ST_END;
						end else begin
							state_d = S_CHAR;
						end
					end
					MODE_NEXT: begin
						mreq.addr = read_q;
						if (read_q == HEAD) begin
							status_d = ST_END;
						end else begin
							state_d = S_USE;
						end
					end
					default: begin
						status_d = ST_IGNORED;
					end
				endcase
			end
			S_USE: begin
				state_d = S_DONE;
				case (mode_q)
					MODE_INSERT: begin
						// fill the new slot, then fix the neighbors
						nx_d         = cur_next;
						mreq.addr    = slot;
						mreq.we_chr  = 1'b1;
						mreq.we_prev = 1'b1;
						mreq.we_next = 1'b1;
						mreq.chr     = ch_q;
						mreq.prev    = cursor_q;
						mreq.nxt     = cur_next;
						state_d      = S_WA;
					end
					MODE_LEFT: begin
						cursor_d = rdata.prev;
					end
					MODE_RIGHT: begin
						if (cur_next == HEAD) begin
							status_d = ST_IGNORED;
						end else begin
							cursor_d = cur_next;
						end
					end
					MODE_BACKSP: begin
						pv_d     = rdata.prev;
						nx_d     = rdata.nxt;
						cursor_d = rdata.prev;
						if (rdata.prev == HEAD) begin
							head_next_d = rdata.nxt;
						end else begin
							mreq.addr    = rdata.prev;
							mreq.we_next = 1'b1;
							mreq.nxt     = rdata.nxt;
						end
						state_d = S_WA;
					end
					MODE_NEXT: begin
						read_d    = rdata.nxt;
						mreq.addr = rdata.nxt;
						if (rdata.nxt == HEAD) begin
							status_d = ST_END;
						end else begin
							state_d = S_CHAR;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_WA: begin
				state_d = S_DONE;
				if (nx_q != HEAD) begin
					mreq.addr    = nx_q;
					mreq.we_prev = 1'b1;
					mreq.prev    = (mode_q == MODE_INSERT) ? slot : pv_q;
				end
				if (mode_q == MODE_INSERT) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				if (cursor_q == HEAD) begin
					head_next_d = slot;
				end else begin
					mreq.addr    = cursor_q;
					mreq.we_next = 1'b1;
					mreq.nxt     = slot;
				end
				cursor_d = slot;
				free_d   = free_q + FREE_W'(1);
				state_d  = S_DONE;
			end
			S_CHAR: begin
				char_d  = rdata.chr;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cursor_q    <= '0;
			read_q      <= '0;
			free_q      <= FREE_W'(1);
			head_next_q <= '0;
		end else begin
			state_q     <= state_d;
			cursor_q    <= cursor_d;
			read_q      <= read_d;
			free_q      <= free_d;
			head_next_q <= head_next_d;
		end
	end

	always_ff @(posedge clk) begin
		mode_q   <= mode_d;
		ch_q     <= ch_d;
		nx_q     <= nx_d;
		pv_q     <= pv_d;
		status_q <= status_d;
		char_q   <= char_d;
	end

endmodule
